// ===== rtl/urav_pkg.sv =====
// Package: shared types and constants of the ultrasonic echo range averager.
`timescale 1ns / 1ps

package urav_pkg;

  // Round-trip echo time per centimetre, in microseconds
  localparam int unsigned US_PER_CM = 58;

  // Distance result: 1/16 cm units, saturating
  localparam int unsigned DIST_W   = 15;
  localparam int unsigned DIST_MAX = 32767;

  // Trigger pulse width register
  localparam int unsigned TRIG_W         = 8;
  localparam logic [7:0]  TRIG_WIDTH_RST = 8'd15;

  // Measurement sequencer phases
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_COUNT
  } phase_e;

  // Per-tick flags that travel with each request down the pipeline
  typedef struct packed {
    logic trig;
    logic busy;
    logic done;
  } tick_t;

endpackage

// ===== rtl/urav_ctrl.sv =====
// Module: input register and measurement sequencer of the range averager.
`timescale 1ns / 1ps

module urav_ctrl import urav_pkg::*; #(
  parameter int unsigned NUM_SAMPLES     = 5,
  parameter int unsigned ECHO_COUNT_BITS = 16,
  localparam int unsigned SUM_W          = ECHO_COUNT_BITS + $clog2(NUM_SAMPLES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  logic              start_req_i,
  input  logic              echo_level_i,
  input  logic [TRIG_W-1:0] trig_width_i,
  output logic              vld_o,
  output tick_t             tick_o,
  output logic [SUM_W-1:0]  sum_o
);

  localparam int unsigned IDX_W = $clog2(NUM_SAMPLES + 1);

  logic                       in_vld_q;
  logic                       start_q;
  logic                       echo_q;

  phase_e                     phase_q, phase_d;
  logic [TRIG_W-1:0]          trig_cnt_q, trig_cnt_d;
  logic [ECHO_COUNT_BITS-1:0] echo_time_q, echo_time_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  logic [SUM_W-1:0]           sum_q, sum_d;

  logic                       vld_q;
  tick_t                      tick_q, tick_d;
  logic [SUM_W-1:0]           sum_out_q;

  logic [TRIG_W-1:0]          width_eff;
  logic [SUM_W-1:0]           sum_next;
  logic [IDX_W-1:0]           idx_next;

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (en_i) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      start_q <= start_req_i;
      echo_q  <= echo_level_i;
    end
  end

  // A zero width still gives a one-tick pulse
  assign width_eff = (trig_width_i == '0) ? TRIG_W'(1) : trig_width_i;
  assign sum_next  = sum_q + SUM_W'(echo_time_q);
  assign idx_next  = idx_q + IDX_W'(1);

  // Sequencer: next state and per-tick flags
  always_comb begin
    phase_d     = phase_q;
    trig_cnt_d  = trig_cnt_q;
    echo_time_d = echo_time_q;
    idx_d       = idx_q;
    sum_d       = sum_q;
    tick_d      = '{trig: 1'b0, busy: 1'b1, done: 1'b0};
    unique case (phase_q)
      PH_TRIG: begin
        if (trig_cnt_q >= width_eff) begin
          phase_d = PH_WAIT;
        end else begin
          tick_d.trig = 1'b1;
          trig_cnt_d  = trig_cnt_q + TRIG_W'(1);
        end
      end
      PH_WAIT: begin
        if (echo_q) begin
          echo_time_d = ECHO_COUNT_BITS'(1);
          phase_d     = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo_q) begin
          // Saturate an overlong echo
          if (echo_time_q != '1) begin
            echo_time_d = echo_time_q + ECHO_COUNT_BITS'(1);
          end
        end else begin
          sum_d = sum_next;
          idx_d = idx_next;
          if (idx_next >= IDX_W'(NUM_SAMPLES)) begin
            tick_d.done = 1'b1;
            tick_d.busy = 1'b0;
            phase_d     = PH_IDLE;
          end else begin
            tick_d.trig = 1'b1;
            trig_cnt_d  = TRIG_W'(1);
            phase_d     = PH_TRIG;
          end
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (start_q) begin
          tick_d.trig = 1'b1;
          trig_cnt_d  = TRIG_W'(1);
          idx_d       = '0;
          sum_d       = '0;
          echo_time_d = '0;
          phase_d     = PH_TRIG;
        end else begin
          tick_d.busy = 1'b0;
        end
      end
    endcase
  end

  // Advance the sequencer once per request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      trig_cnt_q  <= '0;
      echo_time_q <= '0;
      idx_q       <= '0;
      sum_q       <= '0;
      vld_q       <= 1'b0;
    end else if (en_i) begin
      vld_q <= in_vld_q;
      if (in_vld_q) begin
        phase_q     <= phase_d;
        trig_cnt_q  <= trig_cnt_d;
        echo_time_q <= echo_time_d;
        idx_q       <= idx_d;
        sum_q       <= sum_d;
      end
    end
  end

  // Hold the tick flags and the running sum for the divider
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tick_q    <= tick_d;
      sum_out_q <= sum_d;
    end
  end

  assign vld_o  = vld_q;
  assign tick_o = tick_q;
  assign sum_o  = sum_out_q;

`ifndef SYNTHESIS
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q && tick_q.done |-> !tick_q.busy && !tick_q.trig)
    else $error("done flagged while busy or triggering");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(phase_q) && $stable(sum_q) && $stable(idx_q))
    else $error("sequencer moved during a stall");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_IDLE |-> idx_q < IDX_W'(NUM_SAMPLES))
    else $error("sample index out of range");
`endif

endmodule

// ===== rtl/urav_avg.sv =====
// Module: averaging divider pipeline and result register of the range averager.
`timescale 1ns / 1ps

module urav_avg import urav_pkg::*; #(
  parameter int unsigned NUM_SAMPLES     = 5,
  parameter int unsigned ECHO_COUNT_BITS = 16,
  localparam int unsigned SUM_W          = ECHO_COUNT_BITS + $clog2(NUM_SAMPLES)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  tick_t             tick_i,
  input  logic [SUM_W-1:0]  sum_i,
  output logic              out_valid_o,
  output tick_t             tick_o,
  output logic [DIST_W-1:0] distance_o
);

  // Quotient of (sum*16 + DEN/2) / DEN by reciprocal multiply plus one fix-up
  localparam int unsigned NUM_W    = SUM_W + 5;
  localparam int unsigned DEN      = US_PER_CM * NUM_SAMPLES;
  localparam int unsigned DEN_W    = $clog2(DEN + 1);
  localparam int unsigned R_W      = DEN_W + 1;
  localparam logic [63:0] RECIP64  = (64'd1 << NUM_W) / DEN;
  localparam logic [NUM_W-1:0] RECIP = RECIP64[NUM_W-1:0];

  logic [NUM_W-1:0]   num;
  logic [2*NUM_W-1:0] prod_d;
  logic [NUM_W-1:0]   quo0;
  logic [NUM_W-1:0]   back;
  logic [R_W-1:0]     rem_d;
  logic [NUM_W:0]     quo1;
  logic [DIST_W-1:0]  dist_d;

  logic               v2_q, v3_q, v4_q;
  tick_t              tick2_q, tick3_q, tick4_q;
  logic [2*NUM_W-1:0] prod_q;
  logic [NUM_W-1:0]   num2_q;
  logic [NUM_W-1:0]   quo_q;
  logic [R_W-1:0]     rem_q;
  logic [DIST_W-1:0]  dist_q;

  // Scale to 1/16 cm and add half the divisor for rounding
  assign num    = {1'b0, sum_i, 4'b0000} + NUM_W'(DEN / 2);
  assign prod_d = (2 * NUM_W)'(num) * (2 * NUM_W)'(RECIP);

  // Estimate is low by at most one; find the remainder
  assign quo0  = prod_q[2*NUM_W-1:NUM_W];
  assign back  = NUM_W'(quo0 * NUM_W'(DEN));
  assign rem_d = R_W'(num2_q - back);

  // Apply the fix-up and saturate
  assign quo1   = {1'b0, quo_q} + (NUM_W + 1)'(rem_q >= R_W'(DEN));
  assign dist_d = (quo1 > (NUM_W + 1)'(DIST_MAX)) ? DIST_W'(DIST_MAX) : quo1[DIST_W-1:0];

  // Valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      dist_q <= '0;
    end else if (en_i) begin
      v2_q <= vld_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
      // Hold the last average until a sequence ends
      if (v3_q && tick3_q.done) begin
        dist_q <= dist_d;
      end
    end
  end

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tick2_q <= tick_i;
      prod_q  <= prod_d;
      num2_q  <= num;
      tick3_q <= tick2_q;
      quo_q   <= quo0;
      rem_q   <= rem_d;
      tick4_q <= tick3_q;
    end
  end

  assign out_valid_o = v4_q;
  assign tick_o      = tick4_q;
  assign distance_o  = dist_q;

`ifndef SYNTHESIS
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> rem_q < R_W'(2 * DEN))
    else $error("reciprocal estimate off by more than one");

  a_est_low : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> back <= num2_q)
    else $error("reciprocal estimate too high");

  a_dist_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(dist_q) && $stable(v4_q))
    else $error("result register changed during a stall");
`endif

endmodule

// ===== rtl/ultrasonic_echo_range_averager.sv =====
// Top level: ultrasonic echo range averager.
`timescale 1ns / 1ps

// Feed one request per microsecond tick (start_req_i, echo_level_i). Each
// request yields exactly one result, in order. Each result passes through
// the input register, the sequencer register and the three-stage
// reciprocal-multiply divider that forms the average sum*16/(58*NUM_SAMPLES),
// rounded with halves up and saturated at 32767. One request is taken every
// cycle while the output side keeps up. trigger_width_us_i is written through
// the cfg channel (reset 15, zero acts as one tick) and should only change
// while no sequence runs.
module ultrasonic_echo_range_averager import urav_pkg::*; #(
  parameter int unsigned NUM_SAMPLES     = 5,
  parameter int unsigned ECHO_COUNT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [TRIG_W-1:0] trigger_width_us_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              start_req_i,
  input  logic              echo_level_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              trigger_out_o,
  output logic              busy_res_o,
  output logic              done_res_o,
  output logic [DIST_W-1:0] distance_q4_o
);

  localparam int unsigned SUM_W = ECHO_COUNT_BITS + $clog2(NUM_SAMPLES);

  logic [TRIG_W-1:0] trig_width_q;
  logic              adv;
  logic              s1_vld;
  tick_t             s1_tick;
  logic [SUM_W-1:0]  s1_sum;
  tick_t             out_tick;

  // Trigger width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trig_width_q <= TRIG_WIDTH_RST;
    end else if (cfg_valid_i) begin
      trig_width_q <= trigger_width_us_i;
    end
  end

  assign cfg_ready_o = 1'b1;

  // Advance the whole pipeline unless a result waits unread
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  urav_ctrl #(
    .NUM_SAMPLES     (NUM_SAMPLES),
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (adv),
    .in_valid_i   (in_valid_i),
    .start_req_i  (start_req_i),
    .echo_level_i (echo_level_i),
    .trig_width_i (trig_width_q),
    .vld_o        (s1_vld),
    .tick_o       (s1_tick),
    .sum_o        (s1_sum)
  );

  urav_avg #(
    .NUM_SAMPLES     (NUM_SAMPLES),
    .ECHO_COUNT_BITS (ECHO_COUNT_BITS)
  ) u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .vld_i       (s1_vld),
    .tick_i      (s1_tick),
    .sum_i       (s1_sum),
    .out_valid_o (out_valid_o),
    .tick_o      (out_tick),
    .distance_o  (distance_q4_o)
  );

  assign trigger_out_o = out_tick.trig;
  assign busy_res_o    = out_tick.busy;
  assign done_res_o    = out_tick.done;

endmodule

// ===== test/ultrasonic_echo_range_averager_test.sv =====
// Testbench: ultrasonic echo range averager, checked per tick against a local predictor.
`timescale 1ns / 1ps

module ultrasonic_echo_range_averager_test;
  import urav_pkg::*;

  localparam int unsigned SAMPLES_PER_AVG = 5;
  localparam int unsigned ECHO_BITS       = 16;
  localparam int unsigned ROUND_DIV       = US_PER_CM * SAMPLES_PER_AVG;
  localparam int unsigned TOTAL_TICKS     = 1600;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES   = 20;
  localparam int unsigned ONE_CM_Q4       = 16;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    logic [DIST_W-1:0] distance;
  } echo_result_t;

  typedef enum logic {
    ROW_TICKS,
    ROW_WIDTH_WRITE
  } row_kind_e;

  // One directed row: a run of identical ticks, or a trigger width write
  typedef struct {
    row_kind_e    kind;
    logic [7:0]   width;
    logic         start;
    logic         echo;
    int unsigned  reps;
    echo_result_t want;
  } stim_row_t;

  logic              clk_i  = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [TRIG_W-1:0] trigger_width_us_i = TRIG_WIDTH_RST;
  logic              in_valid_i   = 1'b0;
  logic              in_ready_o;
  logic              start_req_i  = 1'b0;
  logic              echo_level_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i  = 1'b0;
  logic              trigger_out_o;
  logic              busy_res_o;
  logic              done_res_o;
  logic [DIST_W-1:0] distance_q4_o;

  // Predictor state, at its reset values
  phase_e                 rng_phase   = PH_IDLE;
  logic [7:0]             trig_cnt    = '0;
  logic [ECHO_BITS-1:0]   echo_us     = '0;
  int unsigned            samples_got = 0;
  int unsigned            echo_sum    = 0;
  logic [DIST_W-1:0]      last_dist   = '0;
  logic [TRIG_W-1:0]      set_width   = TRIG_WIDTH_RST;

  echo_result_t expected_q[$];
  stim_row_t    plan[$];
  bit           gaps_on = 1'b1;
  bit           pinned_now = 1'b0;
  echo_result_t pinned_want;
  int unsigned  mismatches = 0;
  int unsigned  results_seen = 0;
  int unsigned  ticks_sent = 0;
  int unsigned  readings = 0;
  int unsigned  widths_written = 0;
  int unsigned  idle_cycles = 0;

  ultrasonic_echo_range_averager #(
    .NUM_SAMPLES     (SAMPLES_PER_AVG),
    .ECHO_COUNT_BITS (ECHO_BITS)
  ) DUT (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .trigger_width_us_i (trigger_width_us_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .start_req_i        (start_req_i),
    .echo_level_i       (echo_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .trigger_out_o      (trigger_out_o),
    .busy_res_o         (busy_res_o),
    .done_res_o         (done_res_o),
    .distance_q4_o      (distance_q4_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Advance the range sequencer by one microsecond tick
  function automatic echo_result_t range_tick(input logic start, input logic echo);
    echo_result_t r;
    logic [8:0]   pulse_len;
    int unsigned  q;
    pulse_len = (set_width == '0) ? 9'd1 : {1'b0, set_width};
    r = '0;
    r.busy = 1'b1;
    case (rng_phase)
      PH_TRIG: begin
        if (trig_cnt >= pulse_len) begin
          rng_phase = PH_WAIT;
        end else begin
          r.trig   = 1'b1;
          trig_cnt = trig_cnt + 8'd1;
        end
      end
      PH_WAIT: begin
        if (echo) begin
          echo_us   = ECHO_BITS'(1);
          rng_phase = PH_COUNT;
        end
      end
      PH_COUNT: begin
        if (echo) begin
          if (echo_us != '1) echo_us = echo_us + 1'b1;
        end else begin
          // Echo fell: bank the count, then retrigger or give the average
          echo_sum    = echo_sum + 32'(echo_us);
          samples_got = samples_got + 1;
          if (samples_got >= SAMPLES_PER_AVG) begin
            q         = (echo_sum * 16 + ROUND_DIV / 2) / ROUND_DIV;
            last_dist = (q > DIST_MAX) ? DIST_MAX[DIST_W-1:0] : q[DIST_W-1:0];
            r.done    = 1'b1;
            r.busy    = 1'b0;
            rng_phase = PH_IDLE;
          end else begin
            r.trig    = 1'b1;
            trig_cnt  = 8'd1;
            rng_phase = PH_TRIG;
          end
        end
      end
      default: begin
        rng_phase = PH_IDLE;
        if (start) begin
          r.trig      = 1'b1;
          trig_cnt    = 8'd1;
          samples_got = 0;
          echo_sum    = 0;
          echo_us     = '0;
          rng_phase   = PH_TRIG;
        end else begin
          r.busy = 1'b0;
        end
      end
    endcase
    r.distance = last_dist;
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input int unsigned want,
                                        input int unsigned got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("mismatch at result %0d: %s expected %0d, got %0d",
               results_seen, what, want, got);
    end
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [7:0] width,
                                  input logic start, input logic echo,
                                  input int unsigned reps, input logic trig,
                                  input logic busy, input logic done,
                                  input int unsigned distance);
    stim_row_t r;
    r.kind  = kind;
    r.width = width;
    r.start = start;
    r.echo  = echo;
    r.reps  = reps;
    r.want  = '{trig, busy, done, distance[DIST_W-1:0]};
    plan.push_back(r);
  endfunction

  // Hold a tick request until accepted; call and return at a falling edge
  task automatic send_tick(input logic s, input logic e);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 16) : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_req_i  = s;
    echo_level_i = e;
    in_valid_i   = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold off new requests until every predicted result is back
  task automatic drain_results();
    in_valid_i = 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_trigger_width(input logic [7:0] w);
    trigger_width_us_i = w;
    cfg_valid_i        = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    widths_written++;
  endtask

  // Predict on accepted requests, check accepted results
  always @(posedge clk_i) begin
    echo_result_t predicted;
    echo_result_t got;
    echo_result_t want;
    if (cfg_valid_i && cfg_ready_o) set_width = trigger_width_us_i;
    if (in_valid_i && in_ready_o) begin
      predicted = range_tick(start_req_i, echo_level_i);
      expected_q.push_back(pinned_now ? pinned_want : predicted);
      ticks_sent++;
      if (predicted.done) readings++;
    end
    if (out_valid_o && out_ready_i) begin
      results_seen++;
      got = '{trigger_out_o, busy_res_o, done_res_o, distance_q4_o};
      if (expected_q.size() == 0) begin
        note_mismatch("result with no request pending, distance", 0, got.distance);
      end else begin
        want = expected_q.pop_front();
        if (got.trig !== want.trig) note_mismatch("trigger_out", want.trig, got.trig);
        if (got.busy !== want.busy) note_mismatch("busy_res", want.busy, got.busy);
        if (got.done !== want.done) note_mismatch("done_res", want.done, got.done);
        if (got.distance !== want.distance) begin
          note_mismatch("distance_q4", want.distance, got.distance);
        end
      end
    end
  end

  // End the run when no channel moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("status: fail");
      $finish;
    end
  end

  // Result side: stall a random number of cycles before taking each result
  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      stall = gaps_on ? $urandom_range(0, 16) : 0;
      if (stall != 0) begin
        out_ready_i = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    logic        s;
    logic        e;
    int unsigned pick;
    int unsigned rise_delay;
    int unsigned high_left;
    int unsigned phase_items;
    int unsigned p;
    logic [7:0]  w;
    rise_delay = 0;
    high_left  = 0;

    // Idle, start, start while busy, silent wait, then five 1 cm echoes
    add_row(ROW_TICKS, 8'd0, 1'b0, 1'b1, 3, 1'b0, 1'b0, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b1, 1'b0, 1, 1'b1, 1'b1, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b1, 1'b1, 14, 1'b1, 1'b1, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b0, 1'b0, 40, 1'b0, 1'b1, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b0, 1'b1, US_PER_CM, 1'b0, 1'b1, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b0, 1'b0, 1, 1'b1, 1'b1, 1'b0, 0);
    for (int k = 1; k < SAMPLES_PER_AVG; k++) begin
      add_row(ROW_TICKS, 8'd0, 1'b0, 1'b0, 20, 1'b0, 1'b1, 1'b0, 0);
      add_row(ROW_TICKS, 8'd0, 1'b0, 1'b1, US_PER_CM, 1'b0, 1'b1, 1'b0, 0);
      if (k == SAMPLES_PER_AVG - 1) begin
        add_row(ROW_TICKS, 8'd0, 1'b0, 1'b0, 1, 1'b0, 1'b0, 1'b1, ONE_CM_Q4);
      end else begin
        add_row(ROW_TICKS, 8'd0, 1'b0, 1'b0, 1, 1'b1, 1'b1, 1'b0, 0);
      end
    end
    // Zero width acts as a single-tick trigger pulse
    add_row(ROW_WIDTH_WRITE, 8'd0, 1'b0, 1'b0, 0, 1'b0, 1'b0, 1'b0, 0);
    add_row(ROW_TICKS, 8'd0, 1'b1, 1'b1, 1, 1'b1, 1'b1, 1'b0, ONE_CM_Q4);
    add_row(ROW_TICKS, 8'd0, 1'b0, 1'b1, 1, 1'b0, 1'b1, 1'b0, ONE_CM_Q4);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Walk the directed table; long runs go without gaps
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WIDTH_WRITE) begin
        drain_results();
        write_trigger_width(plan[i].width);
      end else begin
        gaps_on = (plan[i].reps < 100);
        for (int unsigned n = 1; n <= plan[i].reps; n++) begin
          pinned_now  = (n == plan[i].reps);
          pinned_want = plan[i].want;
          send_tick(plan[i].start, plan[i].echo);
        end
        pinned_now = 1'b0;
      end
    end
    gaps_on = 1'b1;

    // Random sequences; each phase ends idle so the width can change
    p = 0;
    while (ticks_sent < TOTAL_TICKS) begin
      if (p != 0) begin
        case (p)
          1:       w = 8'd1;
          2:       w = TRIG_WIDTH_RST;
          3:       w = 8'd10;
          default: w = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(13, 60))
                                                    : 8'($urandom_range(0, 12));
        endcase
        drain_results();
        write_trigger_width(w);
      end
      phase_items = 0;
      while (phase_items < 250 || rng_phase != PH_IDLE) begin
        if (rng_phase == PH_IDLE) s = ($urandom_range(0, 2) == 0);
        else s = ($urandom_range(0, 1) == 1);
        // Shape the echo from where the sequencer stands
        case (rng_phase)
          PH_WAIT: begin
            if (rise_delay != 0) begin
              e = 1'b0;
              rise_delay--;
            end else begin
              e = 1'b1;
            end
          end
          PH_COUNT: begin
            if (high_left != 0) begin
              e = 1'b1;
              high_left--;
            end else begin
              e = 1'b0;
            end
          end
          default: begin
            e = ($urandom_range(0, 3) == 0);
            rise_delay = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
            pick = $urandom_range(0, 99);
            high_left = (pick < 85) ? $urandom_range(0, 12) :
                        (pick < 97) ? $urandom_range(13, 200) : $urandom_range(201, 600);
          end
        endcase
        phase_items++;
        if ($urandom_range(0, 99) == 0) gaps_on = !gaps_on;
        if ($urandom_range(0, 299) == 0) drain_results();
        send_tick(s, e);
      end
      p++;
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d ticks, %0d averaged readings, %0d trigger width writes",
             ticks_sent, readings, widths_written);
    $display("1 cm echoes, zero and short widths, random stalls, %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/urav_pkg.sv
rtl/urav_ctrl.sv
rtl/urav_avg.sv
rtl/ultrasonic_echo_range_averager.sv
test/ultrasonic_echo_range_averager_test.sv
